[src/catmull_rom_spline_sampler_unit_assert.svh]
// Assertion macros for the Catmull-Rom spline sampler.
// Files that assert include this header; it depends on clk and rst_n in scope.
`ifndef CATMULL_ROM_SPLINE_SAMPLER_UNIT_ASSERT_SVH
`define CATMULL_ROM_SPLINE_SAMPLER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CRS_ASSERT(lbl, prop, msg)
`define CRS_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

[src/crs_pkg.sv]
// Shared types and constants of the Catmull-Rom spline sampler.
// Depends on nothing; every other file but the assertion header imports it.
package crs_pkg;

  localparam int DEF_MAX_POINTS = 256;
  localparam int COORD_W        = 32;
  localparam int DVD_W          = 37;   // dividend of one weight division
  localparam int DEN_W          = 19;   // divisor 2*S^3
  localparam int QUO_W          = 18;   // quotient bits per division
  localparam int W_W            = 19;   // signed weight, Q2.16
  localparam int ACC_W          = 53;   // sum of four weight-point products

  localparam logic [5:0] SPC_RESET = 6'd20;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPC    = 2'd0;
  localparam logic [1:0] CFG_COUNT  = 2'd1;
  localparam logic [1:0] CFG_CLOSED = 2'd2;

  // Request opcodes.
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

endpackage

[src/crs_if.sv]
// Channel interfaces of the spline sampler: request input and sample output.
// Depends on crs_pkg for the coordinate width.
interface crs_in_if;
  import crs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [7:0]                point_index;
  logic [7:0]                segment_index;
  logic signed [COORD_W-1:0] x_in;
  logic signed [COORD_W-1:0] y_in;
  modport source (output valid, op, point_index, segment_index, x_in, y_in, input ready);
  modport sink (input valid, op, point_index, segment_index, x_in, y_in, output ready);
endinterface

interface crs_out_if;
  import crs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_out;
  logic signed [COORD_W-1:0] y_out;
  logic                      last_point;
  modport source (output valid, x_out, y_out, last_point, input ready);
  modport sink (input valid, x_out, y_out, last_point, output ready);
endinterface

[src/crs_pstore.sv]
// Control point memory: one write port and one read port with registered data.
// Depends on crs_pkg for the point type.
module crs_pstore import crs_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS,
  parameter int AW = $clog2(MAX_POINTS)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  point_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output point_t        rdata
);

  point_t mem [MAX_POINTS];
  point_t rdata_r;

  // Write on request; read data is registered and appears in the cycle after the read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/crs_wdiv.sv]
// Four-lane restoring divider that yields the blend weights, one bit per cycle.
// Depends on crs_pkg for the operand widths.
module crs_wdiv import crs_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [3:0][DVD_W-1:0]       dvd,
  input  logic [DEN_W-1:0]            den,
  output logic                        done,
  output logic [3:0][QUO_W-1:0]       quo
);

  logic [4:0]                   cnt_r;
  logic                         done_r;
  logic [3:0][DEN_W-1:0]        rem_r;
  logic [3:0][QUO_W-1:0]        lo_r;
  logic [3:0][QUO_W-1:0]        q_r;
  logic [3:0][DEN_W:0]          trial;
  logic [3:0]                   fits;

  // Trial subtraction per lane; the remainder always stays below the divisor.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      trial[i] = {rem_r[i], lo_r[i][QUO_W-1]};
      fits[i]  = (trial[i] >= {1'b0, den});
    end
  end

  // Control: count the quotient bits and flag the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 5'd1) && !start;
      if (start) begin
        cnt_r <= 5'(QUO_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  // Datapath: the high dividend bits seed the remainder, low bits shift in.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      if (start) begin
        rem_r[i] <= dvd[i][DVD_W-1:QUO_W];
        lo_r[i]  <= dvd[i][QUO_W-1:0];
        q_r[i]   <= '0;
      end else if (cnt_r != '0) begin
        rem_r[i] <= fits[i] ? DEN_W'(trial[i] - {1'b0, den}) : trial[i][DEN_W-1:0];
        lo_r[i]  <= {lo_r[i][QUO_W-2:0], 1'b0};
        q_r[i]   <= {q_r[i][QUO_W-2:0], fits[i]};
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

[src/catmull_rom_spline_sampler_unit.sv]
// Catmull-Rom spline sampler: one request at a time; a store is written as it is accepted.
// An evaluate reads four points, then builds each of the S+1 samples in turn: the weight
// numerators, the weight divider, a multiply-accumulate over the four points, rounding,
// and the output, which waits until the output channel takes the sample.
// A two-point segment emits its two stored points as its two samples.
// Synchronous reset restores the configuration and control registers; the point memory is not cleared.
module catmull_rom_spline_sampler_unit import crs_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  crs_in_if.sink     in_ch,
  crs_out_if.source  out_ch
);

`include "catmull_rom_spline_sampler_unit_assert.svh"

  localparam int AW = $clog2(MAX_POINTS);
  localparam int IW = (AW > 9) ? AW : 9;
  localparam logic [8:0] N_MAX = 9'((MAX_POINTS > 511) ? 511 : MAX_POINTS);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_PAIR, S_PREP1, S_PREP2, S_NUM, S_DIV, S_MAC, S_ROUND, S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [5:0] spc_r;
  logic [8:0] pcnt_r;
  logic       closed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r    <= SPC_RESET;
      pcnt_r   <= '0;
      closed_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPC:    spc_r    <= cfg_wdata[5:0];
        CFG_COUNT:  pcnt_r   <= cfg_wdata;
        CFG_CLOSED: closed_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  // Request decode: segment check and the four point indexes.
  logic       in_acc;
  logic [8:0] n_c, k_c;
  logic       seg_ok_c, pair_c;
  logic [3:0][8:0] idx_c;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign n_c    = (pcnt_r > N_MAX) ? N_MAX : pcnt_r;
  assign k_c    = {1'b0, in_ch.segment_index};

  always_comb begin
    pair_c   = (n_c == 9'd2);
    seg_ok_c = 1'b0;
    idx_c    = '0;
    priority if (n_c < 9'd2) begin
      seg_ok_c = 1'b0;
    end else if (pair_c) begin
      seg_ok_c = (k_c == 9'd0);
      idx_c[1] = 9'd1;
    end else if (k_c < n_c - 9'd1) begin
      seg_ok_c = 1'b1;
      idx_c[0] = (k_c == 9'd0) ? (closed_r ? n_c - 9'd1 : 9'd0) : k_c - 9'd1;
      idx_c[1] = k_c;
      idx_c[2] = k_c + 9'd1;
      idx_c[3] = (k_c == n_c - 9'd2) ? (closed_r ? 9'd0 : n_c - 9'd1) : k_c + 9'd2;
    end else if ((k_c == n_c - 9'd1) && closed_r) begin
      seg_ok_c = 1'b1;
      idx_c[0] = n_c - 9'd2;
      idx_c[1] = n_c - 9'd1;
      idx_c[2] = 9'd0;
      idx_c[3] = 9'd1;
    end else begin
      seg_ok_c = 1'b0;
    end
  end

  // Point memory ports.
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  point_t          mem_wdata, mem_rdata;
  logic [3:0][8:0] idx_r;
  logic [2:0]      rc_r;
  logic [IW-1:0]   waddr_w, raddr_w;

  assign waddr_w   = IW'(in_ch.point_index);
  assign raddr_w   = IW'(idx_r[rc_r[1:0]]);
  assign mem_we    = in_acc && (in_ch.op == OP_STORE) && (int'(in_ch.point_index) < MAX_POINTS);
  assign mem_waddr = waddr_w[AW-1:0];
  assign mem_wdata = '{y: in_ch.y_in, x: in_ch.x_in};
  assign mem_re    = (state_r == S_READ) && (rc_r < 3'd4);
  assign mem_raddr = raddr_w[AW-1:0];

  crs_pstore #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_pstore (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sample datapath registers.
  point_t [3:0]          pts_r;
  logic                  pair_r;
  logic [5:0]            s_r, j_r;
  logic [11:0]           s2_r, j2_r;
  logic [17:0]           s3_r, j3_r, j2s_r, js2_r;
  logic [3:0][DVD_W-1:0] dvd_r;
  logic                  div_start_r, div_done;
  logic [3:0][QUO_W-1:0] div_quo;
  logic [3:0][W_W-1:0]   w_r;
  logic [2:0]            m_r;
  logic signed [50:0]    prod_x_r, prod_y_r;
  logic signed [ACC_W-1:0] acc_x_r, acc_y_r;
  logic                  out_valid_r, last_r;
  logic signed [COORD_W-1:0] x_out_r, y_out_r;

  // Weight numerators times 2^16, offset by 2^16 divisors so they stay positive.
  // The smallest weight is about -0.074, so one divisor of offset before the scaling is enough.
  logic signed [23:0]    a3, a2s, as2, as3;
  logic signed [3:0][23:0] num_c;
  logic [3:0][23:0]      num_o_c;
  logic [3:0][DVD_W-1:0] dvd_c;

  assign a3     = $signed(24'(j3_r));
  assign a2s    = $signed(24'(j2s_r));
  assign as2    = $signed(24'(js2_r));
  assign as3    = $signed(24'(s3_r));

  always_comb begin
    num_c[0] = -a3 + (a2s <<< 1) - as2;
    num_c[1] = (a3 <<< 1) + a3 - (a2s <<< 2) - a2s + (as3 <<< 1);
    num_c[2] = -(a3 <<< 1) - a3 + (a2s <<< 2) + as2;
    num_c[3] = a3 - a2s;
    for (int i = 0; i < 4; i++) begin
      num_o_c[i] = num_c[i] + 24'({s3_r, 1'b0});
      dvd_c[i]   = DVD_W'({num_o_c[i], 16'h0}) + DVD_W'(s3_r);
    end
  end

  crs_wdiv u_wdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .dvd   (dvd_r),
    .den   ({s3_r, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Products of the selected weight and point, and the rounded, saturated sum.
  logic signed [50:0]      pw_c, px_c, py_c;
  logic signed [ACC_W-1:0] rx_c, ry_c;
  logic signed [COORD_W-1:0] sx_c, sy_c;

  assign pw_c = 51'($signed(w_r[m_r[1:0]]));
  assign px_c = 51'(pts_r[m_r[1:0]].x);
  assign py_c = 51'(pts_r[m_r[1:0]].y);
  assign rx_c = (acc_x_r + ACC_W'(32768)) >>> 16;
  assign ry_c = (acc_y_r + ACC_W'(32768)) >>> 16;

  always_comb begin
    priority if (rx_c > ACC_W'(64'sd2147483647)) sx_c = 32'sh7fffffff;
    else if (rx_c < -ACC_W'(64'sd2147483648))    sx_c = 32'sh80000000;
    else                                         sx_c = rx_c[31:0];
    priority if (ry_c > ACC_W'(64'sd2147483647)) sy_c = 32'sh7fffffff;
    else if (ry_c < -ACC_W'(64'sd2147483648))    sy_c = 32'sh80000000;
    else                                         sy_c = ry_c[31:0];
  end

  // Sequencer: read points, then build each sample in turn.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_ch.op == OP_EVAL) && seg_ok_c) begin
            idx_r   <= idx_c;
            pair_r  <= pair_c;
            s_r     <= (spc_r == '0) ? 6'd1 : spc_r;
            s2_r    <= (spc_r == '0) ? 12'd1 : 12'(spc_r) * 12'(spc_r);
            j_r     <= '0;
            rc_r    <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          s3_r <= 18'(s2_r) * 18'(s_r);
          if (rc_r != '0) begin
            pts_r[2'(rc_r - 3'd1)] <= mem_rdata;
          end
          rc_r <= rc_r + 3'd1;
          if (rc_r == 3'd4) begin
            state_r <= pair_r ? S_PAIR : S_PREP1;
          end
        end
        S_PAIR: begin
          x_out_r     <= (j_r == '0) ? pts_r[0].x : pts_r[1].x;
          y_out_r     <= (j_r == '0) ? pts_r[0].y : pts_r[1].y;
          last_r      <= (j_r != '0);
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_PREP1: begin
          j2_r    <= 12'(j_r) * 12'(j_r);
          js2_r   <= 18'(j_r) * 18'(s2_r);
          state_r <= S_PREP2;
        end
        S_PREP2: begin
          j3_r    <= 18'(j2_r) * 18'(j_r);
          j2s_r   <= 18'(j2_r) * 18'(s_r);
          state_r <= S_NUM;
        end
        S_NUM: begin
          dvd_r       <= dvd_c;
          div_start_r <= 1'b1;
          state_r     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            for (int i = 0; i < 4; i++) begin
              w_r[i] <= {1'b0, div_quo[i]} - W_W'(65536);
            end
            m_r     <= '0;
            acc_x_r <= '0;
            acc_y_r <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (m_r < 3'd4) begin
            prod_x_r <= pw_c * px_c;
            prod_y_r <= pw_c * py_c;
          end
          if (m_r != '0) begin
            acc_x_r <= acc_x_r + ACC_W'(prod_x_r);
            acc_y_r <= acc_y_r + ACC_W'(prod_y_r);
          end
          m_r <= m_r + 3'd1;
          if (m_r == 3'd4) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          x_out_r     <= sx_c;
          y_out_r     <= sy_c;
          last_r      <= (j_r == s_r);
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            j_r         <= j_r + 6'd1;
            priority if (last_r) state_r <= S_IDLE;
            else if (pair_r)     state_r <= S_PAIR;
            else                 state_r <= S_PREP1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.x_out      = x_out_r;
  assign out_ch.y_out      = y_out_r;
  assign out_ch.last_point = last_r;

  // A pending sample blocks new requests.
  `CRS_ASSERT(a_out_blocks_in, out_ch.valid |-> !in_ch.ready, "request taken while sample pending")
  // Weights only arrive while the sequencer waits for them.
  `CRS_ASSERT(a_div_in_state, div_done |-> (state_r == S_DIV), "divider finished out of step")
  // A store completes in the cycle it is accepted.
  `CRS_ASSERT(a_store_one_cycle,
    (in_ch.valid && in_ch.ready && (in_ch.op == OP_STORE)) |=> in_ch.ready,
    "store did not complete in one cycle")
  // The final sample of a request returns the block to idle.
  `CRS_ASSERT(a_last_to_idle,
    (out_ch.valid && out_ch.ready && out_ch.last_point) |=> in_ch.ready,
    "block not idle after last sample")

endmodule

[tb/tb.sv]
// Self-checking testbench of the Catmull-Rom spline sampler unit.
// Depends on crs_pkg, the channel interfaces in crs_if.sv and the sampler top level.
module tb;
  import crs_pkg::*;

  typedef struct {
    logic        op;
    logic [7:0]  pidx;
    logic [7:0]  seg;
    logic [31:0] x;
    logic [31:0] y;
  } request_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        last;
  } sample_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;

  crs_in_if  in_ch();
  crs_out_if out_ch();

  catmull_rom_spline_sampler_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Model state: point store, registers and the queues between both sides.
  point_t      ctrl_pts[256];
  logic [5:0]  steps_reg;
  logic [8:0]  count_reg;
  logic        closed_reg;
  request_t    pending_q[$];
  sample_t     sample_q[$];
  int          errors;
  int          results_seen;
  longint      cycles;

  // Clock and a single reset at the start of the run.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Picks the four control points of a segment; returns 0, 2 or 4 points used.
  function automatic int segment_points(input int n, input int k, input logic cl,
                                        output int idx[4]);
    idx = '{0, 0, 0, 0};
    if (n > 256) n = 256;
    if (n < 2) return 0;
    if (n == 2) begin
      idx = '{0, 1, 0, 1};
      return (k == 0) ? 2 : 0;
    end
    if (k < n - 1) begin
      idx[0] = (k == 0) ? (cl ? n - 1 : 0) : k - 1;
      idx[1] = k;
      idx[2] = k + 1;
      idx[3] = (k == n - 2) ? (cl ? 0 : n - 1) : k + 2;
      return 4;
    end
    if (k == n - 1 && cl) begin
      idx = '{n - 2, n - 1, 0, 1};
      return 4;
    end
    return 0;
  endfunction

  function automatic longint floor_div(input longint a, input longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // Applies one accepted request and queues the samples it must produce.
  task automatic predict_samples(input request_t r);
    int      idx[4];
    int      used;
    longint  s, s3, den, j, j2, j3, w, ax, ay;
    longint  num[4];
    sample_t smp;
    if (r.op == OP_STORE) begin
      ctrl_pts[r.pidx] = '{y: r.y, x: r.x};
      return;
    end
    used = segment_points(count_reg, r.seg, closed_reg, idx);
    if (used == 2) begin
      sample_q.push_back('{ctrl_pts[0].x, ctrl_pts[0].y, 1'b0});
      sample_q.push_back('{ctrl_pts[1].x, ctrl_pts[1].y, 1'b1});
    end else if (used == 4) begin
      s = (steps_reg == 0) ? 1 : steps_reg;
      s3 = s * s * s;
      den = 2 * s3;
      for (j = 0; j <= s; j++) begin
        j2 = j * j;
        j3 = j2 * j;
        num[0] = -j3 + 2 * j2 * s - j * s * s;
        num[1] = 3 * j3 - 5 * j2 * s + 2 * s3;
        num[2] = -3 * j3 + 4 * j2 * s + j * s * s;
        num[3] = j3 - j2 * s;
        ax = 0;
        ay = 0;
        for (int m = 0; m < 4; m++) begin
          w = floor_div(num[m] * 65536 + s3, den);
          ax += w * longint'(ctrl_pts[idx[m]].x);
          ay += w * longint'(ctrl_pts[idx[m]].y);
        end
        smp.x = clamp32(floor_div(ax + 32768, 65536));
        smp.y = clamp32(floor_div(ay + 32768, 65536));
        smp.last = (j == s);
        sample_q.push_back(smp);
      end
    end
  endtask

  // Driver: bursts of transactions with random gaps, fed from pending_q.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.op            <= OP_STORE;
      in_ch.point_index   <= '0;
      in_ch.segment_index <= '0;
      in_ch.x_in          <= '0;
      in_ch.y_in          <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid) begin
        predict_samples(pending_q.pop_front());
      end
      if (burst_left == 0 && gap_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_ch.valid         <= 1'b1;
        in_ch.op            <= pending_q[0].op;
        in_ch.point_index   <= pending_q[0].pidx;
        in_ch.segment_index <= pending_q[0].seg;
        in_ch.x_in          <= pending_q[0].x;
        in_ch.y_in          <= pending_q[0].y;
        burst_left--;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each sample transaction and drives a stall pattern on ready.
  int  hold_left;
  bit  long_hold_done;
  int  ready_mode;
  sample_t exp_smp;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready   <= 1'b0;
      hold_left      = 0;
      long_hold_done = 0;
      ready_mode     = 0;
      results_seen   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (sample_q.size() == 0) begin
          $error("unexpected sample x=%h y=%h last=%b",
                 out_ch.x_out, out_ch.y_out, out_ch.last_point);
          errors++;
        end else begin
          exp_smp = sample_q.pop_front();
          if (out_ch.x_out !== exp_smp.x) begin
            $error("x_out expected %h actual %h", exp_smp.x, out_ch.x_out);
            errors++;
          end
          if (out_ch.y_out !== exp_smp.y) begin
            $error("y_out expected %h actual %h", exp_smp.y, out_ch.y_out);
            errors++;
          end
          if (out_ch.last_point !== exp_smp.last) begin
            $error("last_point expected %b actual %b", exp_smp.last, out_ch.last_point);
            errors++;
          end
        end
      end
      if (cycles % 64 == 0) ready_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (results_seen >= 12 && !long_hold_done) begin
        // One long hold-off so that the block backs up into its input.
        long_hold_done = 1;
        hold_left = 400;
        out_ch.ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Cycle counter with a generous limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus side: which slots have been written so far.
  bit written[256];

  task automatic add_store(input int slot, input logic [31:0] x, input logic [31:0] y);
    pending_q.push_back('{OP_STORE, slot[7:0], 8'($urandom), x, y});
    written[slot] = 1;
  endtask

  task automatic add_eval(input int k);
    pending_q.push_back('{OP_EVAL, 8'($urandom), k[7:0], $urandom, $urandom});
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_ch.valid || sample_q.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[8:0];
    @(posedge clk);
    case (idx)
      CFG_SPC:    steps_reg  = val[5:0];
      CFG_COUNT:  count_reg  = val[8:0];
      default:    closed_reg = val[0];
    endcase
  endtask

  task automatic set_curve(input int spc, input int cnt, input int cl);
    wait_idle();
    write_reg(CFG_SPC, spc);
    write_reg(CFG_COUNT, cnt);
    write_reg(CFG_CLOSED, cl);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  // A random phase: mostly valid evaluates over written points, some noise.
  task automatic random_phase(input int items);
    int spc, cnt, cl, lim, k, used, miss;
    int idx[4];
    case ($urandom_range(0, 9))
      0: spc = 63;
      1: spc = 0;
      default: spc = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 9))
      0: cnt = $urandom_range(0, 1);
      1: cnt = $urandom_range(256, 511);
      default: cnt = $urandom_range(2, 12);
    endcase
    cl = $urandom_range(0, 1);
    set_curve(spc, cnt, cl);
    lim = (cnt > 256) ? 256 : cnt;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 9) < 8 && lim > 0) add_store($urandom_range(0, lim - 1),
                                                           rand_coord(), rand_coord());
        else add_store($urandom_range(0, 255), rand_coord(), rand_coord());
      end else begin
        if ($urandom_range(0, 99) < 15 || lim < 2) k = $urandom_range(0, 255);
        else k = $urandom_range(0, lim - 1);
        used = segment_points(cnt, k, cl[0], idx);
        miss = -1;
        for (int m = 0; m < used; m++) if (!written[idx[m]]) miss = idx[m];
        if (miss >= 0) add_store(miss, rand_coord(), rand_coord());
        else add_eval(k);
      end
    end
  endtask

  // Main sequence: directed phases, random phases, then the verdict.
  initial begin
    errors    = 0;
    cycles    = 0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SPC;
    cfg_wdata = '0;
    steps_reg = SPC_RESET;
    count_reg = '0;
    closed_reg = 1'b0;
    @(posedge rst_n);
    // Directed: extreme coordinates; fewer than two points emit nothing.
    add_store(0, 32'h7fffffff, 32'h80000000);
    add_store(1, 32'h80000000, 32'h7fffffff);
    add_store(2, 32'h00000000, 32'hffffffff);
    add_store(3, 32'h00012345, 32'hfff00100);
    add_eval(0);
    set_curve(4, 1, 0);
    add_eval(0);
    // Two points: the stored points themselves, only on segment 0.
    set_curve(4, 2, 0);
    add_eval(0);
    add_eval(1);
    // Largest step count on a closed three-point curve, closing span included.
    set_curve(63, 3, 1);
    add_eval(0);
    add_eval(2);
    add_eval(3);
    // Zero step count behaves as one; open curve repeats its ends.
    set_curve(0, 4, 0);
    add_eval(0);
    add_eval(2);
    add_eval(3);
    // Count above the store size saturates; the closing span wraps at slot 255.
    set_curve(2, 511, 1);
    add_store(254, 32'h00000100, 32'hffffff00);
    add_store(255, 32'hffffffff, 32'h00000001);
    add_eval(0);
    add_eval(255);
    for (int p = 0; p < 8; p++) random_phase(28);
    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
